@@ rtl/brb_pkg.sv @@
`default_nettype none

package brb_pkg;

  // Storage geometry.
  localparam int unsigned Depth        = 16;
  localparam int unsigned PtrW         = 4;
  localparam int unsigned MaxConsumers = 8;
  localparam int unsigned ConsW        = 3;
  localparam int unsigned DataW        = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_CONSUMERS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOTS_IN_USE     = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [3:0] ACTIVE_RESET = 4'd1;
  localparam logic [4:0] SLOTS_RESET  = 5'd16;

  // Command codes.
  localparam logic CMD_DEPOSIT = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_BLOCKED    = 2'd1;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request fields
    logic exec;    // evaluate and update the ring state
    logic resp;    // present the result
  } brb_ctrl_t;

  // Next pointer value; wraps to zero at the ring length.
  function automatic logic [PtrW-1:0] brb_advance(input logic [PtrW-1:0] p,
                                                  input logic [4:0] len);
    logic [4:0] q;
    q = {1'b0, p} + 5'd1;
    return (q >= len) ? '0 : q[PtrW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/broadcast_ring_buffer_unit.sv @@
`default_nettype none

// Broadcast ring buffer: one producer deposits items and every active
// consumer reads each item once. Raise start_i while busy_o is low to issue
// a deposit (command 0) or a consume for a consumer (command 1). Each request
// gives exactly one result: it is captured, executed (reading the slot data
// memory) and shown for a single cycle with result_valid_o; the receiver
// cannot stall it, so it must be captured then. A new request can be taken
// while a result is shown, but not during execution. A deposit or consume
// that cannot proceed returns the blocked status and should be retried; an
// inactive consumer gets the not-active status. Configuration writes are
// accepted at any time but must only be made while no request is in flight.
module broadcast_ring_buffer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic                          command_i,
  input  wire logic [2:0]                    consumer_i,
  input  wire logic signed [31:0]            item_i,
  output      logic                          result_valid_o,
  output      logic [1:0]                    status_o,
  output      logic signed [31:0]            read_data_o,
  output      logic [3:0]                    slot_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [brb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [brb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import brb_pkg::*;

  brb_ctrl_t ctrl;

  assign cfg_ready_o = 1'b1;

  brb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  brb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .command_i   (command_i),
    .consumer_i  (consumer_i),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status_o),
    .read_data_o (read_data_o),
    .slot_o      (slot_o)
  );

  assign result_valid_o = ctrl.resp;

endmodule

`default_nettype wire

@@ rtl/brb_ram.sv @@
`default_nettype none

module brb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/brb_ctrl.sv @@
`default_nettype none

module brb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output      logic                busy_o,
  output      brb_pkg::brb_ctrl_t  ctrl_o
);
  import brb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // A request is taken in idle or while the previous result is shown.
  assign busy_o = (state_q == S_EXEC);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath.
  assign ctrl_o.load = accept;
  assign ctrl_o.exec = (state_q == S_EXEC);
  assign ctrl_o.resp = (state_q == S_RESP);

endmodule

`default_nettype wire

@@ rtl/brb_datapath.sv @@
`default_nettype none

module brb_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brb_pkg::brb_ctrl_t            ctrl_i,
  input  wire logic                          command_i,
  input  wire logic [2:0]                    consumer_i,
  input  wire logic signed [31:0]            item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [brb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [brb_pkg::CfgDataW-1:0]  cfg_data_i,
  output      logic [1:0]                    status_o,
  output      logic signed [31:0]            read_data_o,
  output      logic [3:0]                    slot_o
);
  import brb_pkg::*;

  // Request registers.
  logic                   cmd_q;
  logic [ConsW-1:0]       cons_q;
  logic [DataW-1:0]       item_q;

  // Configuration registers.
  logic [3:0]             active_q;
  logic [4:0]             slots_q;

  // Ring state.
  logic [PtrW-1:0]         wp_q;
  logic [PtrW-1:0]         rp_q    [MaxConsumers];
  logic [MaxConsumers-1:0] marks_q [Depth];

  // Result registers.
  logic [1:0]             status_q, status_d;
  logic [PtrW-1:0]        slot_q, slot_d;
  logic                   rd_ok_q;

  logic [3:0]             n_eff;
  logic [4:0]             len_eff;
  logic [MaxConsumers-1:0] need;
  logic [MaxConsumers-1:0] bit_c;
  logic [PtrW-1:0]        addr;
  logic [MaxConsumers-1:0] mark;
  logic                   cons_active;
  logic                   dep_ok, con_ok;
  logic [DataW-1:0]       rdata;

  // Capture the request fields when an item is accepted.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= command_i;
      cons_q <= consumer_i;
      item_q <= item_i;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      slots_q  <= SLOTS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ACTIVE_CONSUMERS) begin
        active_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CFG_SLOTS_IN_USE) begin
        slots_q <= cfg_data_i;
      end
    end
  end

  // Clamp the configuration into its legal range.
  always_comb begin
    priority if (active_q == 4'd0)            n_eff = 4'd1;
    else if (active_q > 4'(MaxConsumers))     n_eff = 4'(MaxConsumers);
    else                                      n_eff = active_q;
    priority if (slots_q == 5'd0)             len_eff = 5'd1;
    else if (slots_q > 5'(Depth))             len_eff = 5'(Depth);
    else                                      len_eff = slots_q;
  end

  // Mask of the consumers that must have read a slot before it is reused.
  always_comb begin
    for (int k = 0; k < MaxConsumers; k++) begin
      need[k] = (4'(k) < n_eff);
    end
  end

  // Slot addressed by the request and its decision.
  assign bit_c       = MaxConsumers'(1) << cons_q;
  assign cons_active = ({1'b0, cons_q} < n_eff);
  assign addr        = (cmd_q == CMD_CONSUME) ? rp_q[cons_q] : wp_q;
  assign mark        = marks_q[addr];
  assign dep_ok      = (cmd_q == CMD_DEPOSIT) && ((mark & need) == need);
  assign con_ok      = (cmd_q == CMD_CONSUME) && cons_active && ((mark & bit_c) == '0);

  always_comb begin
    status_d = ST_DONE;
    slot_d   = addr;
    if (cmd_q == CMD_DEPOSIT) begin
      if (!dep_ok) status_d = ST_BLOCKED;
    end else if (!cons_active) begin
      status_d = ST_NOT_ACTIVE;
      slot_d   = '0;
    end else if (!con_ok) begin
      status_d = ST_BLOCKED;
    end
  end

  // Pointer and read-mark updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      for (int i = 0; i < MaxConsumers; i++) rp_q[i] <= '0;
      for (int i = 0; i < Depth; i++) marks_q[i] <= '1;
      rd_ok_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      rd_ok_q <= con_ok;
      if (dep_ok) begin
        marks_q[addr] <= '0;
        wp_q          <= brb_advance(addr, len_eff);
      end
      if (con_ok) begin
        marks_q[addr] <= mark | bit_c;
        rp_q[cons_q]  <= brb_advance(addr, len_eff);
      end
    end
  end

  // Result fields, held for the response cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_q <= status_d;
      slot_q   <= slot_d;
    end
  end

  // Slot data store.
  brb_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.exec && dep_ok),
    .waddr_i (addr),
    .wdata_i (item_q),
    .re_i    (ctrl_i.exec),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign read_data_o = rd_ok_q ? signed'(rdata) : '0;

  // A successful deposit leaves its slot unread by everyone.
  a_dep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.exec && dep_ok) |=> (marks_q[slot_q] == '0))
    else $error("deposit did not clear the read marks");

  // A successful consume sets the consumer's mark on its slot.
  a_con_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.exec && con_ok) |=> ((marks_q[slot_q] & bit_c) != '0))
    else $error("consume did not set the read mark");

  // Read data is nonzero only on a completed consume.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.resp && status_q != ST_DONE) |-> (read_data_o == '0))
    else $error("read data on a failed request");

endmodule

`default_nettype wire

@@ tb/sv/tb_broadcast_ring_buffer_unit.sv @@
`timescale 1ns / 100ps

module tb_broadcast_ring_buffer_unit;
  import brb_pkg::*;

  localparam int unsigned WatchdogLimit = 500;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseItems    = 155;
  localparam int unsigned NumPhases     = 12;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [DataW-1:0] data;
    logic [PtrW-1:0]  slot;
  } ring_result_t;

  // Mirror of the ring state that predicts the result of every request.
  class ring_mirror;
    logic [DataW-1:0]        words [Depth];
    logic [MaxConsumers-1:0] marks [Depth];
    logic [PtrW-1:0]         wr_ptr;
    logic [PtrW-1:0]         rd_ptr [MaxConsumers];
    logic [3:0]              consumers_reg;
    logic [4:0]              length_reg;
    ring_result_t            pending_q [$];
    int                      errors;

    function new();
      for (int i = 0; i < Depth; i++) begin
        words[i] = '0;
        marks[i] = '1;
      end
      for (int i = 0; i < MaxConsumers; i++) rd_ptr[i] = '0;
      wr_ptr        = '0;
      consumers_reg = ACTIVE_RESET;
      length_reg    = SLOTS_RESET;
      errors        = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_ACTIVE_CONSUMERS) consumers_reg = val[3:0];
      else if (idx == CFG_SLOTS_IN_USE) length_reg = val;
    endfunction

    // Out-of-range settings are clamped into the legal range.
    function int unsigned consumer_count();
      if (consumers_reg == 0) return 1;
      if (consumers_reg > MaxConsumers) return MaxConsumers;
      return 32'(consumers_reg);
    endfunction

    function int unsigned ring_len();
      if (length_reg == 0) return 1;
      if (length_reg > Depth) return Depth;
      return 32'(length_reg);
    endfunction

    // A pointer at or past the ring length still wraps to zero on its next step.
    function logic [PtrW-1:0] step_ptr(logic [PtrW-1:0] p);
      int unsigned q;
      q = p + 1;
      return (q >= ring_len()) ? '0 : PtrW'(q);
    endfunction

    function void note_request(logic cmd, logic [ConsW-1:0] cons, logic [DataW-1:0] val);
      ring_result_t            r;
      logic [MaxConsumers-1:0] need;
      int unsigned             n;
      n    = consumer_count();
      need = MaxConsumers'((32'd1 << n) - 32'd1);
      r    = '0;
      r.status = ST_DONE;
      if (cmd == CMD_DEPOSIT) begin
        r.slot = wr_ptr;
        if ((marks[wr_ptr] & need) == need) begin
          words[wr_ptr] = val;
          marks[wr_ptr] = '0;
          wr_ptr = step_ptr(wr_ptr);
        end else begin
          r.status = ST_BLOCKED;
        end
      end else if (cons >= n) begin
        r.status = ST_NOT_ACTIVE;
      end else begin
        r.slot = rd_ptr[cons];
        if (!marks[r.slot][cons]) begin
          r.data = words[r.slot];
          marks[r.slot][cons] = 1'b1;
          rd_ptr[cons] = step_ptr(r.slot);
        end else begin
          r.status = ST_BLOCKED;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [DataW-1:0] data, logic [PtrW-1:0] slot);
      ring_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d data %h slot %0d", $time, st, data, slot);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (data !== e.data) begin
        $display("%0t: read_data expected %h actual %h", $time, e.data, data);
        errors++;
      end
      if (slot !== e.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       command_i = CMD_DEPOSIT;
  logic [ConsW-1:0]           consumer_i = '0;
  logic signed [DataW-1:0]    item_i = '0;
  logic                       cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index_i = CFG_ACTIVE_CONSUMERS;
  logic [CfgDataW-1:0]        cfg_data_i = '0;
  logic                       busy_o;
  logic                       result_valid_o;
  logic [1:0]                 status_o;
  logic signed [DataW-1:0]    read_data_o;
  logic [PtrW-1:0]            slot_o;
  logic                       cfg_ready_o;

  ring_mirror mirror = new();
  int unsigned idle_cycles = 0;

  broadcast_ring_buffer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .consumer_i     (consumer_i),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .read_data_o    (read_data_o),
    .slot_o         (slot_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Results cannot be stalled, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) mirror.check_result(status_o, read_data_o, slot_o);
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_broadcast_ring_buffer_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic cmd, input logic [ConsW-1:0] cons,
                              input logic [DataW-1:0] val);
    start_i    <= 1'b1;
    command_i  <= cmd;
    consumer_i <= cons;
    item_i     <= val;
    do @(posedge clk_i); while (busy_o);
    mirror.note_request(cmd, cons, val);
  endtask

  // Random gap after an item: mostly none, sometimes short, rarely long.
  task automatic pause_sender();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every outstanding request has produced its result.
  task automatic drain();
    start_i <= 1'b0;
    while (mirror.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_reg(idx, val);
  endtask

  // Sets both registers and pokes the unused indexes with random data.
  task automatic set_ring(input logic [CfgDataW-1:0] consumers_raw,
                          input logic [CfgDataW-1:0] length_raw);
    cfg_write(CFG_SPARE_LO, CfgDataW'($urandom));
    cfg_write(CFG_ACTIVE_CONSUMERS, consumers_raw);
    cfg_write(CFG_SLOTS_IN_USE, length_raw);
    cfg_write(CFG_SPARE_HI, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Balanced traffic: deposits and each active consumer are equally likely,
  // with a little noise that may name any consumer.
  task automatic run_traffic(input int unsigned count);
    int unsigned      n;
    int unsigned      pick;
    logic             cmd;
    logic [ConsW-1:0] cons;
    logic [DataW-1:0] val;
    bit               calm;
    n    = mirror.consumer_count();
    calm = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      cons = ConsW'($urandom_range(0, MaxConsumers - 1));
      if (pick < 8) begin
        cmd = 1'($urandom_range(0, 1));
      end else if ($urandom_range(0, n) == 0) begin
        cmd = CMD_DEPOSIT;
      end else begin
        cmd  = CMD_CONSUME;
        cons = ConsW'($urandom_range(0, n - 1));
      end
      val = $urandom;
      case ($urandom_range(0, 19))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = '0;
        3: val = '1;
        default: ;
      endcase
      send_request(cmd, cons, val);
      if (!calm) pause_sender();
    end
  endtask

  // Register settings per phase, extremes and out-of-range values included.
  logic [CfgDataW-1:0] phase_consumers [NumPhases] =
    '{5'd8, 5'd8, 5'd0, 5'd15, 5'd2, 5'd4, 5'd17, 5'd1, 5'd5, 5'd7, 5'd3, 5'd31};
  logic [CfgDataW-1:0] phase_length [NumPhases] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd8, 5'd12, 5'd2, 5'd9, 5'd16};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: unwritten slot, inactive consumers, extreme items.
    send_request(CMD_CONSUME, 3'd0, 32'h0);
    send_request(CMD_CONSUME, 3'd1, 32'h0);
    send_request(CMD_CONSUME, 3'd7, 32'hffff_ffff);
    send_request(CMD_DEPOSIT, 3'd7, 32'h8000_0000);
    send_request(CMD_DEPOSIT, 3'd0, 32'h7fff_ffff);
    send_request(CMD_CONSUME, 3'd0, 32'h0);
    send_request(CMD_CONSUME, 3'd0, 32'h0);
    send_request(CMD_CONSUME, 3'd0, 32'h0);
    drain();

    // Shrink the ring below the write pointer and add two late consumers.
    set_ring(5'd3, 5'd2);
    send_request(CMD_DEPOSIT, 3'd0, 32'h0);
    send_request(CMD_DEPOSIT, 3'd0, 32'hffff_ffff);
    send_request(CMD_CONSUME, 3'd1, 32'h0);
    send_request(CMD_CONSUME, 3'd2, 32'h0);
    send_request(CMD_DEPOSIT, 3'd0, 32'hffff_ffff);
    send_request(CMD_CONSUME, 3'd0, 32'h0);
    send_request(CMD_CONSUME, 3'd1, 32'h0);
    send_request(CMD_DEPOSIT, 3'd0, 32'h5555_5555);
    send_request(CMD_CONSUME, 3'd2, 32'h0);
    send_request(CMD_DEPOSIT, 3'd0, 32'h5555_5555);
    send_request(CMD_CONSUME, 3'd0, 32'h0);
    send_request(CMD_DEPOSIT, 3'd0, 32'haaaa_aaaa);
    drain();

    // Random traffic under each register setting.
    for (int p = 0; p < NumPhases; p++) begin
      set_ring(phase_consumers[p], phase_length[p]);
      run_traffic(PhaseItems);
      drain();
    end

    if (mirror.errors == 0) begin
      $display("tb_broadcast_ring_buffer_unit: done, clean");
    end else begin
      $display("tb_broadcast_ring_buffer_unit: done, errors");
    end
    $finish;
  end

endmodule
